// File: sv/iayu_pkg.sv
// ----------------------------------------------------------------------------
// Angle frame parser package
// Shared types and constants for the serial angle frame parser with yaw
// unwrap: frame status codes, queue entry layout and register indexes.
// ----------------------------------------------------------------------------
package iayu_pkg;

   localparam int BYTE_W      = 8;
   localparam int YAW_RAW_W   = 16;
   localparam int YAW_W       = 17;
   localparam int TURN_W      = 16;
   localparam int CONT_W      = 33;
   localparam int THRESH_W    = 16;
   localparam int COUNT_W     = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'h55;

   // Byte positions inside one frame (header is byte 0).
   localparam logic [COUNT_W-1:0] POS_TYPE     = 4'd1;
   localparam logic [COUNT_W-1:0] POS_YAW_LO   = 4'd6;
   localparam logic [COUNT_W-1:0] POS_YAW_HI   = 4'd7;
   localparam logic [COUNT_W-1:0] POS_CHECKSUM = 4'd10;

   localparam logic [YAW_RAW_W-1:0] RAW_HALF = 16'h8000;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_IDX_ANGLE_TYPE     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IDX_WRAP_THRESHOLD = 2'd1;

   localparam logic [BYTE_W-1:0]   ANGLE_TYPE_RESET     = 8'h53;
   localparam logic [THRESH_W-1:0] WRAP_THRESHOLD_RESET = 16'd30948;

   // Queue between the receiver and the unwrap stage.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_CHECKSUM = 2'd1,
      STATUS_TYPE     = 2'd2
   } frame_status_type;

   typedef struct packed {
      frame_status_type       status;
      logic [YAW_RAW_W-1:0]   raw_yaw;
   } frame_entry_type;

endpackage

// File: sv/iayu_front.sv
// ----------------------------------------------------------------------------
// Frame receiver
// Hunts for the header byte, collects an eleven byte frame with a running
// checksum, and classifies each completed frame into a queue entry.
// ----------------------------------------------------------------------------
module iayu_front
   import iayu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [BYTE_W-1:0]     req_rx_byte,
   input  logic [BYTE_W-1:0]     angle_frame_type,
   input  logic                  queue_full,
   output logic                  push,
   output frame_entry_type       push_entry
);

   logic                 receiving_ff, receiving_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [BYTE_W-1:0]    sum_ff, sum_in;
   logic [BYTE_W-1:0]    type_byte_ff, type_byte_in;
   logic [BYTE_W-1:0]    yaw_lo_ff, yaw_lo_in;
   logic [BYTE_W-1:0]    yaw_hi_ff, yaw_hi_in;
   logic                 accept;
   logic                 complete;
   logic                 idle_after;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign complete  = accept && receiving_ff && (count_ff == POS_CHECKSUM);

   always_comb begin
      receiving_in = receiving_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      type_byte_in = type_byte_ff;
      yaw_lo_in    = yaw_lo_ff;
      yaw_hi_in    = yaw_hi_ff;
      idle_after   = !receiving_ff;
      if (accept && receiving_ff) begin
         if (count_ff == POS_TYPE) begin
            type_byte_in = req_rx_byte;
         end
         if (count_ff == POS_YAW_LO) begin
            yaw_lo_in = req_rx_byte;
         end
         if (count_ff == POS_YAW_HI) begin
            yaw_hi_in = req_rx_byte;
         end
         if (complete) begin
            receiving_in = 1'b0;
            count_in     = '0;
            idle_after   = 1'b1;
         end else begin
            sum_in   = sum_ff + req_rx_byte;
            count_in = count_ff + 1'b1;
         end
      end
      // A checksum byte that equals the header also opens the next frame.
      if (accept && idle_after && (req_rx_byte == HEADER_BYTE)) begin
         receiving_in = 1'b1;
         count_in     = POS_TYPE;
         sum_in       = HEADER_BYTE;
      end
   end

   always_comb begin
      push               = complete;
      push_entry.raw_yaw = {yaw_hi_ff, yaw_lo_ff};
      if (sum_ff != req_rx_byte) begin
         push_entry.status = STATUS_CHECKSUM;
      end else if (type_byte_ff != angle_frame_type) begin
         push_entry.status = STATUS_TYPE;
      end else begin
         push_entry.status = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         receiving_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         receiving_ff <= receiving_in;
         count_ff     <= count_in;
      end
      sum_ff       <= sum_in;
      type_byte_ff <= type_byte_in;
      yaw_lo_ff    <= yaw_lo_in;
      yaw_hi_ff    <= yaw_hi_in;
   end

endmodule

// File: sv/iayu_queue.sv
// ----------------------------------------------------------------------------
// Frame queue
// Two entry register queue that lets the receiver and the unwrap stage
// stall independently.
// ----------------------------------------------------------------------------
module iayu_queue
   import iayu_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  frame_entry_type   push_entry,
   input  logic              pop,
   output frame_entry_type   pop_entry,
   output logic              full,
   output logic              empty
);

   frame_entry_type            slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]     count_ff, count_in;

   assign full      = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign pop_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: sv/iayu_back.sv
// ----------------------------------------------------------------------------
// Yaw unwrap stage
// Folds the raw yaw to signed, tracks threshold crossings in a wrapping
// turn counter and registers the result transaction.
// ----------------------------------------------------------------------------
module iayu_back
   import iayu_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic [THRESH_W-1:0]        wrap_threshold,
   input  logic                       queue_empty,
   input  frame_entry_type            pop_entry,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [1:0]                 rsp_frame_status,
   output logic signed [YAW_W-1:0]    rsp_wrapped_yaw,
   output logic signed [TURN_W-1:0]   rsp_turn_total,
   output logic signed [CONT_W-1:0]   rsp_continuous_yaw
);

   logic                       valid_ff, valid_in;
   frame_status_type           status_ff;
   logic signed [YAW_W-1:0]    wrapped_ff, wrapped_in;
   logic signed [TURN_W-1:0]   turn_ff, turn_in;
   logic signed [CONT_W-1:0]   cont_ff, cont_in;
   logic signed [YAW_W-1:0]    prev_ff, prev_in;
   logic signed [TURN_W-1:0]   counter_ff, counter_in;

   logic signed [YAW_W-1:0]    cur;
   logic signed [YAW_W:0]      thr_pos, thr_neg;
   logic                       inc, dec;
   logic                       good;
   logic signed [TURN_W-1:0]   counter_next;

   assign pop = !queue_empty && (!valid_ff || rsp_ready);
   assign good = (pop_entry.status == STATUS_OK);

   always_comb begin
      // Raw values above one half turn fold to negative.
      cur     = (pop_entry.raw_yaw > RAW_HALF) ? {1'b1, pop_entry.raw_yaw}
                                              : {1'b0, pop_entry.raw_yaw};
      thr_pos = $signed({2'b00, wrap_threshold});
      thr_neg = -thr_pos;
      inc = ($signed({prev_ff[YAW_W-1], prev_ff}) >= thr_pos)
            && ($signed({cur[YAW_W-1], cur}) <= thr_neg);
      dec = ($signed({prev_ff[YAW_W-1], prev_ff}) <= thr_neg)
            && ($signed({cur[YAW_W-1], cur}) >= thr_pos);
      counter_next = counter_ff;
      if (inc && !dec) begin
         counter_next = counter_ff + TURN_W'(1);
      end else if (dec && !inc) begin
         counter_next = counter_ff - TURN_W'(1);
      end

      valid_in   = valid_ff;
      prev_in    = prev_ff;
      counter_in = counter_ff;
      wrapped_in = wrapped_ff;
      turn_in    = turn_ff;
      cont_in    = cont_ff;
      if (valid_ff && rsp_ready) begin
         valid_in = 1'b0;
      end
      if (pop) begin
         valid_in = 1'b1;
         if (good) begin
            prev_in    = cur;
            counter_in = counter_next;
            wrapped_in = cur;
            turn_in    = counter_next;
            cont_in    = CONT_W'($signed({counter_next, 16'h0000}))
                         + CONT_W'(cur);
         end else begin
            wrapped_in = '0;
            turn_in    = '0;
            cont_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         prev_ff    <= '0;
         counter_ff <= '0;
      end else begin
         valid_ff   <= valid_in;
         prev_ff    <= prev_in;
         counter_ff <= counter_in;
      end
      if (pop) begin
         status_ff <= pop_entry.status;
      end
      wrapped_ff <= wrapped_in;
      turn_ff    <= turn_in;
      cont_ff    <= cont_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_frame_status   = status_ff;
   assign rsp_wrapped_yaw    = wrapped_ff;
   assign rsp_turn_total     = turn_ff;
   assign rsp_continuous_yaw = cont_ff;

endmodule

// File: sv/imu_angle_frame_yaw_unwrap_unit.sv
// ----------------------------------------------------------------------------
// IMU angle frame parser with yaw unwrap
// Parses eleven byte angle frames from a serial byte stream and reports a
// continuous yaw built from the folded yaw and a wrapping turn counter.
// ----------------------------------------------------------------------------
// The unit takes one received byte per transaction and can accept a byte in
// every clock cycle; only a full frame queue holds it off. Each completed
// frame produces exactly one result transaction: the receiver writes the
// classified frame into the two entry queue at the edge that accepts the
// checksum byte, and the unwrap stage pops it and registers the result once
// the queue is not empty and its result register is free or being taken
// by the result side. Bytes that do not complete a frame produce no
// result. The status is 0 for an accepted
// angle frame, 1 for a checksum mismatch (which wins over a type mismatch)
// and 2 for a frame of another type; rejected frames report zero yaw
// fields and leave the unwrap state alone. A checksum byte equal to the
// header byte also opens the next frame. Yaw values are in units of
// 180/32768 degree. Configuration writes are taken in any cycle and should
// be made while no frame is being processed.
// ----------------------------------------------------------------------------
module imu_angle_frame_yaw_unwrap_unit
   import iayu_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [BYTE_W-1:0]          req_rx_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [1:0]                 rsp_frame_status,
   output logic signed [YAW_W-1:0]    rsp_wrapped_yaw,
   output logic signed [TURN_W-1:0]   rsp_turn_total,
   output logic signed [CONT_W-1:0]   rsp_continuous_yaw,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_data
);

   // Configuration registers. Writes to an unknown index are dropped.
   logic [BYTE_W-1:0]    angle_type_ff, angle_type_in;
   logic [THRESH_W-1:0]  threshold_ff, threshold_in;

   // Handshake between the receiver, the queue and the unwrap stage.
   logic              push;
   frame_entry_type   push_entry;
   logic              pop;
   frame_entry_type   pop_entry;
   logic              queue_full;
   logic              queue_empty;

   assign csr_ready = 1'b1;

   always_comb begin
      angle_type_in = angle_type_ff;
      threshold_in  = threshold_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_IDX_ANGLE_TYPE: begin
               angle_type_in = csr_data[BYTE_W-1:0];
            end
            CSR_IDX_WRAP_THRESHOLD: begin
               threshold_in = csr_data[THRESH_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_type_ff <= ANGLE_TYPE_RESET;
         threshold_ff  <= WRAP_THRESHOLD_RESET;
      end else begin
         angle_type_ff <= angle_type_in;
         threshold_ff  <= threshold_in;
      end
   end

   // The receiver hunts for headers, keeps a running checksum and
   // classifies each completed frame.
   iayu_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .angle_frame_type (angle_type_ff),
      .queue_full       (queue_full),
      .push             (push),
      .push_entry       (push_entry)
   );

   // The queue decouples the receiver from a stalled result side.
   iayu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .full       (queue_full),
      .empty      (queue_empty)
   );

   // The unwrap stage owns the previous yaw and the turn counter.
   iayu_back u_back (
      .clock              (clock),
      .reset              (reset),
      .wrap_threshold     (threshold_ff),
      .queue_empty        (queue_empty),
      .pop_entry          (pop_entry),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_frame_status   (rsp_frame_status),
      .rsp_wrapped_yaw    (rsp_wrapped_yaw),
      .rsp_turn_total     (rsp_turn_total),
      .rsp_continuous_yaw (rsp_continuous_yaw)
   );

endmodule
